### hw/rtl/bmcs_pkg.sv
// Shared types, constants and helper functions of the block mode cost selector.
`default_nettype none
package bmcs_pkg;

  localparam int unsigned MAX_BLOCK = 4096;
  localparam int unsigned LEN_W     = $clog2(MAX_BLOCK + 1);  // byte count
  localparam int unsigned BITS_W    = LEN_W + 3;              // bit count
  localparam int unsigned RUNS_W    = BITS_W - 1;             // runs of ones
  localparam int unsigned COST_W    = 18;                     // payload / record cost
  localparam int unsigned DIV_W     = 16;                     // divider operand width
  localparam int unsigned NUM_DIV   = 5;                      // quotients per block
  localparam int unsigned DIVIDX_W  = $clog2(NUM_DIV);

  typedef enum logic [2:0] {
    CODE_RAW      = 3'd0,
    CODE_ZERO     = 3'd1,
    CODE_ZTRIM    = 3'd2,
    CODE_ONE_GAP  = 3'd3,
    CODE_ZERO_GAP = 3'd4,
    CODE_ONE_RUN  = 3'd5,
    CODE_NONZERO  = 3'd6
  } bmcs_mode_t;

  // Features of one finished block.
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  lead;
    logic [LEN_W-1:0]  trail;   // zero when block is all zero
    logic [BITS_W-1:0] ones;
    logic [RUNS_W-1:0] runs;
    logic [LEN_W-1:0]  nz;
    logic              ovf;
  } bmcs_feat_t;

  typedef struct packed {
    logic       valid;
    bmcs_feat_t feat;
  } bmcs_push_t;

  typedef struct packed {
    logic       valid;
    bmcs_feat_t feat;
  } bmcs_head_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } bmcs_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } bmcs_div_rsp_t;

  // LEB128 size of a value below 2**21.
  function automatic logic [1:0] vsize(input logic [COST_W-1:0] v);
    logic [1:0] n;
    if (v < COST_W'(128)) begin
      n = 2'd1;
    end else if (v < COST_W'(16384)) begin
      n = 2'd2;
    end else begin
      n = 2'd3;
    end
    return n;
  endfunction

  function automatic logic [3:0] popcount8(input logic [7:0] v);
    logic [3:0] c;
    c = 4'd0;
    for (int i = 0; i < 8; i++) begin
      c = c + 4'(v[i]);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/bmcs_ifs.sv
// Valid/ready channel interfaces for block bytes and mode decisions.
`default_nettype none
interface bmcs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface bmcs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  chosen_mode;
  logic [15:0] record_cost;
  logic [12:0] byte_total;
  logic        overlong;

  modport source (output valid, output chosen_mode, output record_cost,
                  output byte_total, output overlong, input ready);
  modport sink   (input valid, input chosen_mode, input record_cost,
                  input byte_total, input overlong, output ready);
endinterface
`default_nettype wire

### hw/rtl/block_mode_cost_selector_top.sv
// Top level of the block mode cost selector.
//
// in_ch carries one byte of a block per transaction, last_byte set on the
// final byte. out_ch carries one decision per block: cheapest coding mode,
// its estimated record size (saturated to 16 bits), the counted length and
// an overlong flag for bytes dropped past MAX_BLOCK.
//
// Front end takes one byte per cycle and folds it into running features.
// The last byte of a block pushes those features into a two-entry queue;
// in_ch.ready drops only while that queue is full.
// Back end pops one block at a time: five quotients on a shared restoring
// divider (skipped when the divisor is 0), then sizing and comparing the seven
// modes one by one, then loading the output register. The back end takes no
// new block until it has loaded the current one's result; bytes inside blocks
// still stream one per cycle while the queue has room.
// A stalled out_ch holds its result; the back end finishes the next block
// and waits, and the queue keeps absorbing up to two more blocks.
// rst (synchronous) empties the queue, clears features and drops out_ch.valid.
`default_nettype none
module block_mode_cost_selector_top
  import bmcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  bmcs_in_if.sink    in_ch,
  bmcs_out_if.source out_ch
);

  bmcs_push_t push;
  bmcs_head_t head;
  logic       q_full;
  logic       pop;

  bmcs_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push)
  );

  bmcs_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (q_full),
    .pop  (pop),
    .head (head)
  );

  bmcs_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

### hw/rtl/bmcs_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module bmcs_div
  import bmcs_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  bmcs_div_req_t req,
  output bmcs_div_rsp_t rsp
);

  logic [DIV_W-1:0]         rem;
  logic [DIV_W-1:0]         quo;
  logic [DIV_W-1:0]         dvs;
  logic [$clog2(DIV_W):0]   cnt;
  logic                     busy;
  logic                     done;
  logic [DIV_W:0]           shifted;
  logic [DIV_W:0]           trial;

  always_comb begin
    shifted = {rem, quo[DIV_W-1]};
    trial   = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= ($clog2(DIV_W)+1)'(DIV_W);
        rem  <= '0;
        quo  <= req.dividend;
        dvs  <= req.divisor;
      end else if (busy) begin
        if (!trial[DIV_W]) begin
          rem <= trial[DIV_W-1:0];
          quo <= {quo[DIV_W-2:0], 1'b1};
        end else begin
          rem <= shifted[DIV_W-1:0];
          quo <= {quo[DIV_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == ($clog2(DIV_W)+1)'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule
`default_nettype wire

### hw/rtl/bmcs_fifo.sv
// Two-entry queue of block features between front and back.
`default_nettype none
module bmcs_fifo
  import bmcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  bmcs_push_t push,
  output logic       full,
  input  logic       pop,
  output bmcs_head_t head
);

  bmcs_feat_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head.valid = (count != 2'd0);
  assign head.feat  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= push.feat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push.valid) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push.valid) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

### hw/rtl/bmcs_front.sv
// Front end: per-byte feature accumulation, pushes block features at block end.
`default_nettype none
module bmcs_front
  import bmcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  bmcs_in_if.sink     in_ch,
  input  logic        q_full,
  output bmcs_push_t  push
);

  logic [LEN_W-1:0]  byte_count,  byte_count_next;
  logic [LEN_W-1:0]  lead,        lead_next;
  logic [LEN_W-1:0]  zrun,        zrun_next;
  logic              seen_nz,     seen_nz_next;
  logic [LEN_W-1:0]  nz,          nz_next;
  logic [BITS_W-1:0] ones,        ones_next;
  logic [RUNS_W-1:0] runs,        runs_next;
  logic              prev_bit,    prev_bit_next;
  logic              ovf,         ovf_next;
  logic              accept;
  logic              room;
  logic [7:0]        v;
  logic [7:0]        shifted;

  assign in_ch.ready = ~q_full;
  assign accept      = in_ch.valid & in_ch.ready;
  assign v           = in_ch.data_byte;

  always_comb begin
    room            = (byte_count < LEN_W'(MAX_BLOCK));
    shifted         = {prev_bit, v[7:1]};
    byte_count_next = byte_count;
    lead_next       = lead;
    zrun_next       = zrun;
    seen_nz_next    = seen_nz;
    nz_next         = nz;
    ones_next       = ones;
    runs_next       = runs;
    prev_bit_next   = prev_bit;
    ovf_next        = ovf;
    if (!room) begin
      ovf_next = 1'b1;
    end else begin
      byte_count_next = byte_count + 1'b1;
      if (v == 8'd0) begin
        if (!seen_nz) begin
          lead_next = lead + 1'b1;
        end
        zrun_next = zrun + 1'b1;
      end else begin
        seen_nz_next = 1'b1;
        zrun_next    = '0;
        nz_next      = nz + 1'b1;
      end
      ones_next     = ones + BITS_W'(popcount8(v));
      runs_next     = runs + RUNS_W'(popcount8(v & ~shifted));
      prev_bit_next = v[0];
    end
  end

  always_comb begin
    push.valid      = accept & in_ch.last_byte;
    push.feat.len   = byte_count_next;
    push.feat.lead  = lead_next;
    push.feat.trail = seen_nz_next ? zrun_next : '0;
    push.feat.ones  = ones_next;
    push.feat.runs  = runs_next;
    push.feat.nz    = nz_next;
    push.feat.ovf   = ovf_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && in_ch.last_byte)) begin
      byte_count <= '0;
      lead       <= '0;
      zrun       <= '0;
      seen_nz    <= 1'b0;
      nz         <= '0;
      ones       <= '0;
      runs       <= '0;
      prev_bit   <= 1'b0;
      ovf        <= 1'b0;
    end else if (accept) begin
      byte_count <= byte_count_next;
      lead       <= lead_next;
      zrun       <= zrun_next;
      seen_nz    <= seen_nz_next;
      nz         <= nz_next;
      ones       <= ones_next;
      runs       <= runs_next;
      prev_bit   <= prev_bit_next;
      ovf        <= ovf_next;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/bmcs_back.sv
// Back end: average-gap quotients, per-mode cost estimate, cheapest-mode pick.
`default_nettype none
module bmcs_back
  import bmcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  bmcs_head_t head,
  output logic       pop,
  bmcs_out_if.source out_ch
);

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_DIV_START = 6'b000010,
    S_DIV_WAIT  = 6'b000100,
    S_PAY       = 6'b001000,
    S_CMP       = 6'b010000,
    S_OUT       = 6'b100000
  } bmcs_state_t;

  bmcs_state_t         state;
  bmcs_feat_t          feat_r;
  logic [DIVIDX_W-1:0] k_r;
  logic [1:0]          a_r [NUM_DIV];
  bmcs_mode_t          mode_r;
  bmcs_mode_t          best_mode;
  logic [COST_W-1:0]   min_cost;
  logic [COST_W-1:0]   pay_r;
  logic [COST_W-1:0]   pay;
  logic [COST_W-1:0]   cost;
  logic                skip;
  logic                last_div;

  logic                out_valid;
  logic [2:0]          out_mode;
  logic [15:0]         out_cost;
  logic [12:0]         out_len;
  logic                out_ovf;

  bmcs_div_req_t       div_req;
  bmcs_div_rsp_t       div_rsp;

  logic [BITS_W-1:0]   bits;
  logic [BITS_W-1:0]   n0;
  logic [BITS_W-1:0]   n1_min1;

  bmcs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign pop      = (state == S_IDLE) && head.valid;
  assign last_div = (k_r == DIVIDX_W'(NUM_DIV - 1));

  always_comb begin
    bits    = {feat_r.len, 3'b000};
    n0      = bits - feat_r.ones;
    n1_min1 = (feat_r.ones == '0) ? BITS_W'(1) : feat_r.ones;
  end

  // Quotient operands per step
  always_comb begin
    div_req.dividend = '0;
    div_req.divisor  = '0;
    case (k_r)
      DIVIDX_W'(0): begin
        div_req.dividend = DIV_W'(bits);
        div_req.divisor  = DIV_W'(feat_r.ones);
      end
      DIVIDX_W'(1): begin
        div_req.dividend = DIV_W'(bits);
        div_req.divisor  = DIV_W'(n0);
      end
      DIVIDX_W'(2): begin
        div_req.dividend = DIV_W'(bits);
        div_req.divisor  = DIV_W'(feat_r.runs);
      end
      DIVIDX_W'(3): begin
        div_req.dividend = DIV_W'(n1_min1);
        div_req.divisor  = DIV_W'(feat_r.runs);
      end
      DIVIDX_W'(4): begin
        div_req.dividend = DIV_W'(feat_r.len);
        div_req.divisor  = DIV_W'(feat_r.nz);
      end
      default: begin
        div_req.dividend = '0;
        div_req.divisor  = '0;
      end
    endcase
    div_req.start = (state == S_DIV_START) && (div_req.divisor != '0);
  end

  // Payload size of the current mode
  always_comb begin
    case (mode_r)
      CODE_RAW:  pay = COST_W'(feat_r.len);
      CODE_ZERO: pay = '0;
      CODE_ZTRIM:
        pay = COST_W'(vsize(COST_W'(feat_r.lead))) + COST_W'(vsize(COST_W'(feat_r.trail)))
            + COST_W'(feat_r.len - feat_r.lead - feat_r.trail);
      CODE_ONE_GAP:
        pay = COST_W'(vsize(COST_W'(feat_r.ones)))
            + COST_W'(feat_r.ones) * COST_W'(a_r[0]);
      CODE_ZERO_GAP:
        pay = COST_W'(vsize(COST_W'(n0))) + COST_W'(n0) * COST_W'(a_r[1]);
      CODE_ONE_RUN:
        pay = COST_W'(vsize(COST_W'(feat_r.runs)))
            + COST_W'(feat_r.runs) * COST_W'({1'b0, a_r[2]} + {1'b0, a_r[3]});
      CODE_NONZERO:
        pay = COST_W'(vsize(COST_W'(feat_r.nz)))
            + COST_W'(feat_r.nz) * COST_W'({1'b0, a_r[4]} + 3'd1);
      default:   pay = '0;
    endcase
  end

  always_comb begin
    cost = COST_W'(1) + COST_W'(vsize(COST_W'(feat_r.len))) + COST_W'(vsize(pay_r)) + pay_r;
    skip = (mode_r == CODE_ZERO) && (feat_r.nz != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_OUT) && (!out_valid || out_ch.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (head.valid) begin
            feat_r <= head.feat;
            k_r    <= '0;
            state  <= S_DIV_START;
          end
        end
        S_DIV_START: begin
          if (div_req.divisor == '0) begin
            a_r[k_r] <= 2'd0;
            if (last_div) begin
              state <= S_PAY;
            end else begin
              k_r <= k_r + 1'b1;
            end
          end else begin
            state <= S_DIV_WAIT;
          end
        end
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            a_r[k_r] <= vsize(COST_W'(div_rsp.quotient));
            if (last_div) begin
              state <= S_PAY;
            end else begin
              k_r   <= k_r + 1'b1;
              state <= S_DIV_START;
            end
          end
        end
        S_PAY: begin
          pay_r <= pay;
          state <= S_CMP;
        end
        S_CMP: begin
          if (!skip && (cost < min_cost)) begin
            min_cost  <= cost;
            best_mode <= mode_r;
          end
          if (mode_r == CODE_NONZERO) begin
            state <= S_OUT;
          end else begin
            mode_r <= bmcs_mode_t'(mode_r + 3'd1);
            state  <= S_PAY;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ch.ready) begin
            out_mode  <= best_mode;
            out_cost  <= (min_cost > COST_W'(16'hFFFF)) ? 16'hFFFF : min_cost[15:0];
            out_len   <= feat_r.len[12:0];
            out_ovf   <= feat_r.ovf;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // Start of the mode scan
      if ((state == S_DIV_START && div_req.divisor == '0 && last_div) ||
          (state == S_DIV_WAIT && div_rsp.done && last_div)) begin
        mode_r    <= CODE_RAW;
        best_mode <= CODE_RAW;
        min_cost  <= '1;
      end
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.chosen_mode  = out_mode;
  assign out_ch.record_cost  = out_cost;
  assign out_ch.byte_total   = out_len;
  assign out_ch.overlong     = out_ovf;

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIV_WAIT))
    else $error("divider done outside wait state");

  a_out_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) && (!out_valid || out_ch.ready) |=> out_valid && (state == S_IDLE))
    else $error("result not loaded into output register");

  a_zero_mode_legal: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> !((best_mode == CODE_ZERO) && (feat_r.nz != '0)))
    else $error("zero mode chosen for block with nonzero bytes");

endmodule
`default_nettype wire

### dv/testbench.sv
// Testbench for block_mode_cost_selector_top: directed and random blocks checked against a predictor.
module testbench;
  import bmcs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Stop stimulus once the run has pushed this many bytes.
  localparam int unsigned RANDOM_ITEMS = 1550;
  // Cycles with no transaction on either channel before the run is declared hung.
  // Worst honest case is a long receiver stall on top of the back end's work.
  localparam int unsigned IDLE_LIMIT   = 3000;
  // Quiet time after the last decision; covers the back-end latency.
  localparam int unsigned DRAIN_CYCLES = 150;

  // One block decision as the block should report it.
  typedef struct {
    bmcs_mode_t  mode;
    logic [15:0] cost;
    logic [12:0] length;
    logic        overlong;
  } block_decision_t;

  // Content styles for generated blocks.
  typedef enum {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_SPARSE,
    FILL_DENSE,
    FILL_PATTERN,
    FILL_FRAMED
  } fill_style_t;

  logic clk;
  logic rst;

  bmcs_in_if  in_ch();
  bmcs_out_if out_ch();

  block_mode_cost_selector_top DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 4 ns clock.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Decisions still owed by the block, oldest first.
  block_decision_t pending_decisions[$];

  int unsigned fail_count   = 0;
  int unsigned bytes_sent   = 0;
  int unsigned idle_cycles  = 0;
  int unsigned stall_left   = 0;
  bit          steady_input  = 0;  // sender adds no random gaps while set
  bit          steady_output = 0;  // receiver starts no new random stalls while set

  // Running features of the block being received.
  logic [12:0] blk_bytes;
  logic [12:0] blk_lead_zeros;
  logic [12:0] blk_zero_run;
  logic        blk_any_nonzero;
  logic [12:0] blk_nonzero;
  logic [15:0] blk_ones;
  logic [14:0] blk_one_runs;
  logic        blk_prev_bit;
  logic        blk_dropped;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  task automatic clear_features();
    blk_bytes       = '0;
    blk_lead_zeros  = '0;
    blk_zero_run    = '0;
    blk_any_nonzero = 1'b0;
    blk_nonzero     = '0;
    blk_ones        = '0;
    blk_one_runs    = '0;
    blk_prev_bit    = 1'b0;
    blk_dropped     = 1'b0;
  endtask

  // LEB128 length of an unsigned value.
  function automatic longint unsigned leb_size(input longint unsigned v);
    longint unsigned n;
    n = 1;
    while (v >= 64'd128) begin
      v = v >> 7;
      n++;
    end
    return n;
  endfunction

  // Size of the average gap span/count; nothing when count is zero.
  function automatic longint unsigned gap_size(input longint unsigned span,
                                                input longint unsigned count);
    longint unsigned q;
    if (count == 0) begin
      return 0;
    end
    q = span / count;
    if (q == 0) begin
      q = 1;
    end
    return leb_size(q);
  endfunction

  // Estimated payload bytes of one mode for the current features.
  function automatic longint unsigned mode_payload(input bmcs_mode_t mode);
    longint unsigned len, bits, n1, n0, runs, nz, lead, trail;
    len   = blk_bytes;
    bits  = len * 8;
    n1    = blk_ones;
    n0    = bits - n1;
    runs  = blk_one_runs;
    nz    = blk_nonzero;
    lead  = blk_lead_zeros;
    trail = blk_any_nonzero ? longint'(blk_zero_run) : 0;  // all-zero: lead covers it
    case (mode)
      CODE_RAW:      return len;
      CODE_ZERO:     return 0;
      CODE_ZTRIM:    return leb_size(lead) + leb_size(trail) + (len - lead - trail);
      CODE_ONE_GAP:  return leb_size(n1) + n1 * gap_size(bits, n1);
      CODE_ZERO_GAP: return leb_size(n0) + n0 * gap_size(bits, n0);
      CODE_ONE_RUN:  return leb_size(runs) +
                            runs * (gap_size(bits, runs) + gap_size(n1 ? n1 : 1, runs));
      default:       return leb_size(nz) + nz * (gap_size(len, nz) + 1);
    endcase
  endfunction

  // Cheapest record over all applicable modes; ties keep the lower mode.
  function automatic block_decision_t decide_block();
    block_decision_t d;
    bmcs_mode_t      mode;
    longint unsigned payload, record, best;
    best   = '1;
    d.mode = CODE_RAW;
    mode   = mode.first();
    repeat (mode.num()) begin
      if (!(mode == CODE_ZERO && blk_nonzero != 0)) begin
        payload = mode_payload(mode);
        record  = 1 + leb_size(blk_bytes) + leb_size(payload) + payload;
        if (record < best) begin
          best   = record;
          d.mode = mode;
        end
      end
      mode = mode.next();
    end
    d.cost     = (best > 64'hFFFF) ? 16'hFFFF : best[15:0];
    d.length   = blk_bytes;
    d.overlong = blk_dropped;
    return d;
  endfunction

  // Fold one accepted byte into the features; the final byte queues a decision.
  task automatic absorb_byte(input logic [7:0] b, input logic fin);
    logic prev;
    if (blk_bytes >= MAX_BLOCK) begin
      blk_dropped = 1'b1;
    end else begin
      blk_bytes++;
      if (b == 8'h00) begin
        if (!blk_any_nonzero) begin
          blk_lead_zeros++;
        end
        blk_zero_run++;
      end else begin
        blk_any_nonzero = 1'b1;
        blk_zero_run    = '0;
        blk_nonzero++;
      end
      // MSB first; a run starts on a one whose predecessor is zero
      prev = blk_prev_bit;
      for (int i = 7; i >= 0; i--) begin
        if (b[i]) begin
          blk_ones++;
          if (!prev) begin
            blk_one_runs++;
          end
        end
        prev = b[i];
      end
      blk_prev_bit = b[0];
    end
    if (fin) begin
      pending_decisions.push_back(decide_block());
      clear_features();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Idle and stall timing
  // ---------------------------------------------------------------------------

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int unsigned pick_delay(input bit steady);
    int unsigned r;
    if (steady) begin
      return 0;
    end
    r = $urandom_range(99);
    if (r < 65) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(2, 1);
    end else if (r < 97) begin
      return $urandom_range(8, 3);
    end
    return $urandom_range(40, 15);
  endfunction

  // Receiver: ready drops for random stretches, changed on the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
      stall_left = pick_delay(steady_output);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Send one byte; returns on the falling edge after its transaction.
  // valid is only lowered when a gap follows, so it never toggles within a step.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    gap = pick_delay(steady_input);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= fin;
    do @(posedge clk); while (!in_ch.ready);
    absorb_byte(b, fin);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Stop sending until every queued decision has come out.
  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_decisions.size() != 0);
    @(negedge clk);
  endtask

  function automatic logic [7:0] fill_byte(input fill_style_t style);
    logic [7:0] patterns[7] = '{8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h01, 8'h80, 8'h3C};
    case (style)
      FILL_ZERO:    return 8'h00;
      FILL_SPARSE:  return ($urandom_range(99) < 85) ? 8'h00 : 8'($urandom);
      FILL_DENSE:   return ($urandom_range(99) < 75) ? 8'hFF : 8'($urandom);
      FILL_PATTERN: return patterns[$urandom_range(6)];
      default:      return 8'($urandom);
    endcase
  endfunction

  // One whole block; framed blocks get zero runs at both ends.
  task automatic send_block(input int unsigned len, input fill_style_t style);
    int unsigned lead, trail;
    logic [7:0]  b;
    lead  = 0;
    trail = 0;
    if (style == FILL_FRAMED) begin
      lead  = $urandom_range(len / 2);
      trail = $urandom_range(len - lead);
    end
    for (int unsigned i = 0; i < len; i++) begin
      if (i < lead || i >= len - trail) begin
        b = 8'h00;
      end else begin
        b = fill_byte(FILL_RANDOM);
      end
      if (style != FILL_FRAMED) begin
        b = fill_byte(style);
      end
      send_byte(b, i == len - 1);
    end
  endtask

  task automatic send_list(input logic [7:0] bytes[$]);
    foreach (bytes[i]) begin
      send_byte(bytes[i], i == bytes.size() - 1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // One-byte blocks at the extremes of the byte value.
  task automatic test_single_byte_blocks();
    send_list('{8'h00});
    send_list('{8'hFF});
    send_list('{8'h80});
    send_list('{8'h01});
  endtask

  // All-zero block (zero mode applies, no trailing count), zero runs at both
  // ends, one runs that cross a byte boundary, alternating bits, and 00 then FF.
  task automatic test_zero_and_runs();
    send_list('{8'h00, 8'h00, 8'h00});
    send_list('{8'h00, 8'h00, 8'h81, 8'h00, 8'h00});
    send_list('{8'h01, 8'h80, 8'hFF});
    send_list('{8'hAA, 8'h55});
    send_list('{8'h00, 8'hFF});
  endtask

  // Random blocks: mostly short, some long, varied content and timing.
  task automatic test_random_blocks();
    int unsigned len, r, blocks;
    fill_style_t style;
    blocks = 0;
    while (bytes_sent < RANDOM_ITEMS) begin
      // every dozen blocks redraw, for each side, whether it runs without gaps
      if (blocks % 12 == 0) begin
        steady_input  = ($urandom_range(3) == 0);
        steady_output = ($urandom_range(3) == 0);
      end
      r = $urandom_range(99);
      if (r < 55) begin
        len = $urandom_range(8, 1);
      end else if (r < 85) begin
        len = $urandom_range(32, 9);
      end else if (r < 97) begin
        len = $urandom_range(120, 33);
      end else begin
        len = $urandom_range(400, 121);
      end
      style = fill_style_t'($urandom_range(FILL_FRAMED));
      send_block(len, style);
      blocks++;
      if (blocks == 1 || $urandom_range(9) == 0) begin
        hold_until_drained();
      end
    end
    steady_input  = 0;
    steady_output = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Checker: every decision against the oldest one owed
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    block_decision_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_decisions.size() == 0) begin
        $error("decision with none owed: chosen_mode %0d record_cost %0d byte_total %0d",
               out_ch.chosen_mode, out_ch.record_cost, out_ch.byte_total);
        fail_count++;
      end else begin
        want = pending_decisions.pop_front();
        if (out_ch.chosen_mode !== want.mode) begin
          $error("chosen_mode: expected %0d actual %0d", want.mode, out_ch.chosen_mode);
          fail_count++;
        end
        if (out_ch.record_cost !== want.cost) begin
          $error("record_cost: expected %0d actual %0d", want.cost, out_ch.record_cost);
          fail_count++;
        end
        if (out_ch.byte_total !== want.length) begin
          $error("byte_total: expected %0d actual %0d", want.length, out_ch.byte_total);
          fail_count++;
        end
        if (out_ch.overlong !== want.overlong) begin
          $error("overlong: expected %0d actual %0d", want.overlong, out_ch.overlong);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: any transaction on either side resets the idle count.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst              = 1'b1;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = 8'h00;
    in_ch.last_byte  = 1'b0;
    out_ch.ready     = 1'b0;
    clear_features();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_single_byte_blocks();
    test_zero_and_runs();
    test_random_blocks();

    // let the back end finish what is queued, then a quiet tail
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_decisions.size() != 0) begin
      $error("%0d decisions never arrived", pending_decisions.size());
      fail_count++;
    end

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### block_mode_cost_selector_top.f
hw/rtl/bmcs_pkg.sv
hw/rtl/bmcs_ifs.sv
hw/rtl/bmcs_div.sv
hw/rtl/bmcs_fifo.sv
hw/rtl/bmcs_front.sv
hw/rtl/bmcs_back.sv
hw/rtl/block_mode_cost_selector_top.sv
dv/testbench.sv
